// ===== rtl/sha_pkg.sv =====
// shared types, constants and functions of the sha-256 byte stream hasher
package sha_pkg;

  localparam int unsigned BlkBytes = 64;
  localparam int unsigned BlkWords = 16;
  localparam int unsigned Rounds   = 64;
  localparam int unsigned CntW     = 61;
  localparam logic [7:0]  PadByte  = 8'h80;

  localparam logic [31:0] InitH [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19};

  localparam logic [31:0] RoundK [64] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5, 32'h3956C25B, 32'h59F111F1,
    32'h923F82A4, 32'hAB1C5ED5, 32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174, 32'hE49B69C1, 32'hEFBE4786,
    32'h0FC19DC6, 32'h240CA1CC, 32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7, 32'hC6E00BF3, 32'hD5A79147,
    32'h06CA6351, 32'h14292967, 32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85, 32'hA2BFE8A1, 32'hA81A664B,
    32'hC24B8B70, 32'hC76C51A3, 32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5, 32'h391C0CB3, 32'h4ED8AA4A,
    32'h5B9CCA4F, 32'h682E6FF3, 32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2};

  typedef enum logic [2:0] {
    StIdle, StRound, StFold, StPad, StOut
  } ctl_state_e;

  // byte write source
  typedef enum logic [1:0] {
    WrMsg, WrPad, WrZero, WrLen
  } wr_sel_e;

  typedef struct packed {
    logic    wr_en;
    wr_sel_e wr_sel;
    logic    cnt_inc;
    logic    pos_inc;
    logic    start;
    logic    round;
    logic    fold;
    logic    out_load;
    logic    out_shift;
    logic    clear;
  } ctl_cmd_t;

  typedef struct packed {
    logic       pos_full;
    logic [5:0] pos;
    logic       round_last;
    logic [2:0] out_idx;
  } dp_sts_t;

  function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ===== rtl/sha_ctrl.sv =====
// controller state machine of the sha-256 hasher
module sha_ctrl import sha_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  logic     byte_present_i,
  input  logic     msg_end_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output ctl_cmd_t cmd_o,
  input  dp_sts_t  sts_i
);

  ctl_state_e state_q, state_d;
  logic fin_q, fin_d;   // message end pending
  logic len_q, len_d;   // length already written in current pad block
  // true once the pad byte went into a block that still has room for the length, or once a pad block fills
  logic pad_done_q, pad_done_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      fin_q   <= 1'b0;
      len_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      fin_q   <= fin_d;
      len_q   <= len_d;
    end
  end

  logic acc;
  assign acc = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    fin_d   = fin_q;
    len_d   = len_q;
    case (state_q)
      StIdle: begin
        if (acc) begin
          if (byte_present_i && sts_i.pos == 6'd63) begin
            state_d = StRound;
            fin_d   = msg_end_i;
          end else if (msg_end_i) begin
            state_d = StPad;
            fin_d   = 1'b1;
          end
        end
      end
      StRound: if (sts_i.round_last) state_d = StFold;
      StFold: begin
        if (!fin_q) state_d = StIdle;
        else if (len_q) state_d = StOut;
        else state_d = StPad;
        len_d = 1'b0;
      end
      StPad: begin
        // the first pad step writes the pad byte at the current position
        if (sts_i.pos_full) begin
          state_d = StRound;
          len_d   = pad_done_q;
        end
      end
      StOut: begin
        if (out_ready_i && sts_i.out_idx == 3'd7) begin
          state_d = StIdle;
          fin_d   = 1'b0;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  logic pad_first_q, pad_first_d;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pad_first_q <= 1'b0;
    else pad_first_q <= pad_first_d;
  end

  always_comb begin
    cmd_o       = '0;
    cmd_o.wr_sel = WrMsg;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    pad_first_d = pad_first_q;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (acc && byte_present_i) begin
          cmd_o.wr_en   = 1'b1;
          cmd_o.cnt_inc = 1'b1;
          cmd_o.pos_inc = 1'b1;
          if (sts_i.pos == 6'd63) cmd_o.start = 1'b1;
        end
        pad_first_d = 1'b1;
      end
      StRound: cmd_o.round = 1'b1;
      StFold: begin
        cmd_o.fold = 1'b1;
        if (len_q) cmd_o.out_load = 1'b1;
      end
      StPad: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.pos_inc = 1'b1;
        pad_first_d   = 1'b0;
        if (pad_first_q) cmd_o.wr_sel = WrPad;
        else if (sts_i.pos >= 6'd56 && !len_q && pad_done_q) cmd_o.wr_sel = WrLen;
        else cmd_o.wr_sel = WrZero;
        if (sts_i.pos_full) cmd_o.start = 1'b1;
      end
      StOut: begin
        out_valid_o = 1'b1;
        if (out_ready_i) cmd_o.out_shift = 1'b1;
        if (out_ready_i && sts_i.out_idx == 3'd7) cmd_o.clear = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    pad_done_d = pad_done_q;
    if (state_q == StIdle) pad_done_d = 1'b0;
    else if (state_q == StPad && sts_i.pos == 6'd63) pad_done_d = 1'b1;
    else if (state_q == StPad && pad_first_q) pad_done_d = sts_i.pos < 6'd56;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pad_done_q <= 1'b0;
    else pad_done_q <= pad_done_d;
  end

endmodule

// ===== rtl/sha_dp.sv =====
// datapath of the sha-256 hasher: block words, schedule, rounds and chain
module sha_dp import sha_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [7:0]  msg_byte_i,
  input  ctl_cmd_t    cmd_i,
  output dp_sts_t     sts_o,
  output logic [31:0] digest_word_o,
  output logic [2:0]  digest_index_o,
  output logic        digest_last_o
);

  logic [5:0]    pos_q;
  logic [CntW-1:0] cnt_q;
  logic [31:0]   h_q [8];
  logic [31:0]   v_q [8];
  logic [31:0]   w_q [BlkWords];
  logic [5:0]    rnd_q;
  logic [31:0]   dig_q [8];
  logic [2:0]    oidx_q;

  logic [63:0] bits;
  assign bits = {cnt_q, 3'b000};

  logic [7:0] wr_byte;
  always_comb begin
    case (cmd_i.wr_sel)
      WrMsg:   wr_byte = msg_byte_i;
      WrPad:   wr_byte = PadByte;
      WrZero:  wr_byte = 8'h00;
      WrLen:   wr_byte = bits[8*(7-pos_q[2:0]) +: 8];
      default: wr_byte = 8'h00;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      cnt_q <= '0;
    end else begin
      if (cmd_i.clear) pos_q <= '0;
      else if (cmd_i.pos_inc) pos_q <= pos_q + 6'd1;
      if (cmd_i.clear) cnt_q <= '0;
      else if (cmd_i.cnt_inc) cnt_q <= cnt_q + 1'b1;
    end
  end

  // message schedule over a 16-word window
  logic [31:0] s0, s1, w_new;
  assign s0 = ror(w_q[1], 7) ^ ror(w_q[1], 18) ^ (w_q[1] >> 3);
  assign s1 = ror(w_q[14], 17) ^ ror(w_q[14], 19) ^ (w_q[14] >> 10);
  assign w_new = w_q[0] + s0 + w_q[9] + s1;

  logic [31:0] ch, mj, bs0, bs1, t1, t2;
  assign ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
  assign mj  = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
  assign bs0 = ror(v_q[0], 2) ^ ror(v_q[0], 13) ^ ror(v_q[0], 22);
  assign bs1 = ror(v_q[4], 6) ^ ror(v_q[4], 11) ^ ror(v_q[4], 25);
  assign t1  = v_q[7] + bs1 + ch + RoundK[rnd_q] + w_q[0];
  assign t2  = bs0 + mj;

  // bytes land big-endian in the schedule window, which doubles as the block buffer
  always_ff @(posedge clk_i) begin
    if (cmd_i.round) begin
      for (int i = 0; i < BlkWords-1; i++) w_q[i] <= w_q[i+1];
      w_q[BlkWords-1] <= w_new;
    end else if (cmd_i.wr_en) begin
      w_q[pos_q[5:2]][{~pos_q[1:0], 3'b000} +: 8] <= wr_byte;
    end
    if (cmd_i.start) begin
      for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
    end else if (cmd_i.round) begin
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rnd_q <= '0;
      oidx_q <= '0;
      for (int i = 0; i < 8; i++) h_q[i] <= InitH[i];
    end else begin
      if (cmd_i.start) rnd_q <= '0;
      else if (cmd_i.round) rnd_q <= rnd_q + 6'd1;
      if (cmd_i.clear) begin
        for (int i = 0; i < 8; i++) h_q[i] <= InitH[i];
      end else if (cmd_i.fold) begin
        for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
      end
      if (cmd_i.out_load) oidx_q <= '0;
      else if (cmd_i.out_shift) oidx_q <= oidx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      for (int i = 0; i < 8; i++) dig_q[i] <= h_q[i] + v_q[i];
    end
  end

  assign sts_o.pos_full   = pos_q == 6'd63;
  assign sts_o.pos        = pos_q;
  assign sts_o.round_last = rnd_q == 6'(Rounds-1);
  assign sts_o.out_idx    = oidx_q;

  assign digest_word_o  = dig_q[oidx_q];
  assign digest_index_o = oidx_q;
  assign digest_last_o  = oidx_q == 3'd7;

endmodule

// ===== rtl/sha256_byte_stream_hasher_unit.sv =====
// top level of the sha-256 byte stream hasher
// Every 64th byte starts a 64-round compression
// (one round per cycle in the shared round unit) followed by a fold step, during which
// input is held off. An end transfer fills the block with pad, zeros and the bit
// length one byte per cycle, compresses one or two final blocks, then presents
// the eight digest words, word 0 first, digest_last on word 7.
module sha256_byte_stream_hasher_unit import sha_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  msg_byte_i,
  input  logic        byte_present_i,
  input  logic        msg_end_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  digest_index_o,
  output logic        digest_last_o
);

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  sha_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .byte_present_i, .msg_end_i,
    .out_valid_o, .out_ready_i, .cmd_o(cmd), .sts_i(sts)
  );

  sha_dp u_dp (
    .clk_i, .rst_ni, .msg_byte_i, .cmd_i(cmd), .sts_o(sts),
    .digest_word_o, .digest_index_o, .digest_last_o
  );

endmodule

// ===== rtl/sha_checker.sv =====
// port-level checks of the sha-256 hasher and their bind
module sha_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [2:0] digest_index_o,
  input logic       digest_last_o
);

  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (digest_last_o == (digest_index_o == 3'd7)))
    else $error("last flag off word seven");

  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_valid_o && in_ready_o))
    else $error("input open while digest out");

  a_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !digest_last_o |=>
      out_valid_o && digest_index_o == $past(digest_index_o) + 3'd1)
    else $error("digest words out of order");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(digest_index_o))
    else $error("stalled digest word moved");

endmodule

bind sha256_byte_stream_hasher_unit sha_checker u_sha_checker (
  .clk_i, .rst_ni, .in_ready_o, .out_valid_o, .out_ready_i, .digest_index_o, .digest_last_o
);
